[hdl/bpa_pkg.sv]
// Shared types, constants and helpers for the bone pose accumulate block.
// Used by bpa_ctrl, bpa_dp and bone_pose_accumulate_core; no dependencies.
`timescale 1ns / 1ps
package bpa_pkg;

    localparam int MAX_BONES = 256;
    localparam int BONE_AW   = $clog2(MAX_BONES);
    localparam int IDX_W     = 8;
    // index widened so that the address part-select always exists
    localparam int IDX_EXT_W = (BONE_AW > IDX_W) ? BONE_AW : IDX_W;
    localparam int ENTRIES   = 12;
    localparam int ROW_W     = ENTRIES * 32;
    localparam int ACC_W     = 50;
    localparam int IN_DATA_W = 176;

    localparam logic signed [ACC_W-1:0] ONE_Q16 = ACC_W'(65536);
    localparam logic [3:0] LAST_ISSUE = 4'd11;
    localparam logic [3:0] LAST_DRAIN = 4'd12;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QMUL,
        ST_LOC,
        ST_MAC,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic loc_en;
        logic mac_en;
        logic col_last;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic child;
        logic out_full;
    } t_sts;

    // saturate a wide signed sum to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(32'sh7fff_ffff);
        lo = -ACC_W'(33'sh0_8000_0000);
        if (v > hi) begin
            return 32'sh7fff_ffff;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

[hdl/bone_pose_accumulate_core.sv]
// Top level of the bone pose accumulate block: world matrix per bone.
// Depends on bpa_pkg, bpa_ctrl and bpa_dp.
//
//  channel  | dir | width | content
//  s_axis   | in  | 176   | tdata: bone_index, parent_index, quat x y z w, pos x y z
//           |     | 1     | tuser: has_parent
//  m_axis   | out | 384   | tdata: m00 m01 m02 m03 m10 .. m23, 32 bits each
//
// A root bone passes from the accept through the quaternion product and local
// matrix states to the output; a child bone also passes through the
// three-multiplier parent product unit, which forms one entry per cycle.
// A new request is taken once the result sits in the output register, even
// if the sink still stalls it. Reset is synchronous, active low, and clears
// control only; the matrix table holds whatever was last written.
`timescale 1ns / 1ps
module bone_pose_accumulate_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // [7:0] bone_index, [15:8] parent_index, [31:16] quat_x, [47:32] quat_y,
    // [63:48] quat_z, [79:64] quat_w, [111:80] pos_x, [143:112] pos_y,
    // [175:144] pos_z
    input  logic [bpa_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    // [0] has_parent
    input  logic                          i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [31:0] m00 .. [383:352] m23, row order
    output logic [bpa_pkg::ROW_W-1:0]     o_m_axis_tdata
);

    bpa_pkg::t_cmd w_cmd;
    bpa_pkg::t_sts w_sts;

    bpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    bpa_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_data       (i_s_axis_tdata),
        .i_has_parent (i_s_axis_tuser),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_data       (o_m_axis_tdata)
    );

endmodule

[hdl/bpa_ctrl.sv]
// Sequencer for the bone pose accumulate block.
// Depends on bpa_pkg for the state, command and status types.
`timescale 1ns / 1ps
module bpa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  bpa_pkg::t_sts i_sts,
    output bpa_pkg::t_cmd o_cmd
);

    bpa_pkg::t_state r_state, n_state;
    logic [3:0]      r_cnt, n_cnt;

    // state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpa_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            bpa_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = bpa_pkg::ST_QMUL;
                end
            end
            bpa_pkg::ST_QMUL: begin
                n_state = bpa_pkg::ST_LOC;
            end
            bpa_pkg::ST_LOC: begin
                o_cmd.loc_en = 1'b1;
                n_cnt        = '0;
                n_state      = i_sts.child ? bpa_pkg::ST_MAC : bpa_pkg::ST_DONE;
            end
            bpa_pkg::ST_MAC: begin
                // issue twelve entries, then drain the adder stage
                o_cmd.mac_en   = (r_cnt <= bpa_pkg::LAST_ISSUE);
                o_cmd.col_last = (r_cnt[1:0] == 2'd3);
                n_cnt          = r_cnt + 4'd1;
                if (r_cnt == bpa_pkg::LAST_DRAIN) begin
                    n_state = bpa_pkg::ST_DONE;
                end
            end
            bpa_pkg::ST_DONE: begin
                if (!i_sts.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = bpa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bpa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/bpa_dp.sv]
// Datapath: local matrix from the quaternion, parent product, matrix table
// and output register. Depends on bpa_pkg; driven by bpa_ctrl commands.
`timescale 1ns / 1ps
module bpa_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bpa_pkg::t_cmd                   i_cmd,
    output bpa_pkg::t_sts                   o_sts,
    input  logic [bpa_pkg::IN_DATA_W-1:0]   i_data,
    input  logic                            i_has_parent,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [bpa_pkg::ROW_W-1:0]       o_data
);

    localparam int AW = bpa_pkg::BONE_AW;
    localparam int EW = bpa_pkg::IDX_EXT_W;
    localparam int NE = bpa_pkg::ENTRIES;

    // captured request
    logic [EW-1:0]      r_slot;
    logic [EW-1:0]      r_par;
    logic               r_child;
    logic signed [15:0] r_qx, r_qy, r_qz, r_qw;
    logic signed [31:0] r_px, r_py, r_pz;

    // quaternion products: xx yy zz xy xz yz wx wy wz
    logic signed [31:0] r_qp [9];
    logic signed [31:0] r_loc [NE];
    logic signed [31:0] r_pm [NE];
    logic signed [31:0] r_wm [NE];

    // parent product pipeline
    logic signed [47:0] r_mp [3];
    logic signed [31:0] r_tr;
    logic               r_a_v;

    // matrix table, one row per bone
    logic [bpa_pkg::ROW_W-1:0] r_mem [bpa_pkg::MAX_BONES];
    logic [bpa_pkg::ROW_W-1:0] r_mq;

    logic                r_ovalid;
    logic [bpa_pkg::ROW_W-1:0] r_odata;

    logic signed [20:0]  w_tw [9];
    logic signed [31:0]  w_lc [NE];
    logic [bpa_pkg::ROW_W-1:0] w_row;
    logic                w_par_ok;
    logic                w_slot_ok;

    // range checks one bit wider so that the bone count itself fits
    assign w_par_ok  = ({1'b0, r_par}  < (EW+1)'(bpa_pkg::MAX_BONES));
    assign w_slot_ok = ({1'b0, r_slot} < (EW+1)'(bpa_pkg::MAX_BONES));

    // capture the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_slot  <= EW'(i_data[7:0]);
            r_par   <= EW'(i_data[15:8]);
            r_child <= i_has_parent;
            r_qx    <= i_data[31:16];
            r_qy    <= i_data[47:32];
            r_qz    <= i_data[63:48];
            r_qw    <= i_data[79:64];
            r_px    <= i_data[111:80];
            r_py    <= i_data[143:112];
            r_pz    <= i_data[175:144];
        end
    end

    // quaternion products
    always_ff @(posedge i_clk) begin
        r_qp[0] <= r_qx * r_qx;
        r_qp[1] <= r_qy * r_qy;
        r_qp[2] <= r_qz * r_qz;
        r_qp[3] <= r_qx * r_qy;
        r_qp[4] <= r_qx * r_qz;
        r_qp[5] <= r_qy * r_qz;
        r_qp[6] <= r_qw * r_qx;
        r_qp[7] <= r_qw * r_qy;
        r_qp[8] <= r_qw * r_qz;
    end

    // twice a*b as Q16.16, floored
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            w_tw[i] = 21'(r_qp[i] >>> 11);
        end
    end

    // local rotation entries and translation column
    always_comb begin
        w_lc[0]  = bpa_pkg::sat32(bpa_pkg::ONE_Q16 - 50'(w_tw[1]) - 50'(w_tw[2]));
        w_lc[1]  = bpa_pkg::sat32(50'(w_tw[3]) - 50'(w_tw[8]));
        w_lc[2]  = bpa_pkg::sat32(50'(w_tw[4]) + 50'(w_tw[7]));
        w_lc[3]  = r_px;
        w_lc[4]  = bpa_pkg::sat32(50'(w_tw[3]) + 50'(w_tw[8]));
        w_lc[5]  = bpa_pkg::sat32(bpa_pkg::ONE_Q16 - 50'(w_tw[0]) - 50'(w_tw[2]));
        w_lc[6]  = bpa_pkg::sat32(50'(w_tw[5]) - 50'(w_tw[6]));
        w_lc[7]  = r_py;
        w_lc[8]  = bpa_pkg::sat32(50'(w_tw[4]) - 50'(w_tw[7]));
        w_lc[9]  = bpa_pkg::sat32(50'(w_tw[5]) + 50'(w_tw[6]));
        w_lc[10] = bpa_pkg::sat32(bpa_pkg::ONE_Q16 - 50'(w_tw[0]) - 50'(w_tw[1]));
        w_lc[11] = r_pz;
    end

    // table read of the parent row, registered
    always_ff @(posedge i_clk) begin
        r_mq <= r_mem[r_par[AW-1:0]];
    end

    // load local matrix and parent; rotate columns and rows while stepping
    always_ff @(posedge i_clk) begin
        if (i_cmd.loc_en) begin
            for (int i = 0; i < NE; i++) begin
                r_loc[i] <= w_lc[i];
                r_pm[i]  <= r_mq[i*32 +: 32];
            end
        end else if (i_cmd.mac_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 4; c++) begin
                    r_loc[r*4+c] <= r_loc[r*4+((c+1)%4)];
                    if (i_cmd.col_last) begin
                        r_pm[r*4+c] <= r_pm[((r+1)%3)*4+c];
                    end
                end
            end
        end
    end

    // product stage: parent row times current local column
    always_ff @(posedge i_clk) begin
        if (i_cmd.mac_en) begin
            for (int k = 0; k < 3; k++) begin
                r_mp[k] <= 48'((64'(r_pm[k]) * 64'(r_loc[k*4])) >>> 16);
            end
            r_tr <= i_cmd.col_last ? r_pm[3] : 32'sd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else begin
            r_a_v <= i_cmd.mac_en;
        end
    end

    // sum stage: results shift in, first entry ends at the bottom
    always_ff @(posedge i_clk) begin
        if (r_a_v) begin
            for (int i = 0; i < NE - 1; i++) begin
                r_wm[i] <= r_wm[i+1];
            end
            r_wm[NE-1] <= bpa_pkg::sat32(50'(r_mp[0]) + 50'(r_mp[1])
                                       + 50'(r_mp[2]) + 50'(r_tr));
        end
    end

    // final matrix: a root, or a child whose parent index is out of range, keeps the local matrix
    always_comb begin
        for (int i = 0; i < NE; i++) begin
            w_row[i*32 +: 32] = (r_child && w_par_ok) ? r_wm[i] : r_loc[i];
        end
    end

    // table write
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load && w_slot_ok) begin
            r_mem[r_slot[AW-1:0]] <= w_row;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_odata <= w_row;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_data         = r_odata;
    assign o_sts.child    = r_child && w_par_ok;
    assign o_sts.out_full = r_ovalid && !i_ready;

endmodule
